// ===== hw/rtl/quaternion_to_euler_macros.svh =====
// Assertion macros for the quaternion to Euler converter.
// Empty when SYNTHESIS is defined.
`ifndef QUATERNION_TO_EULER_MACROS_SVH
`define QUATERNION_TO_EULER_MACROS_SVH
`ifndef SYNTHESIS
`define Q2E_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define Q2E_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define Q2E_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define Q2E_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== hw/rtl/q2e_pkg.sv =====
// Shared types and constants of the quaternion to Euler converter.
// No dependencies.
`default_nettype none
package q2e_pkg;
  localparam int AW = 40;   // CORDIC x/y width (values below 2^37 in magnitude)
  localparam int ZW = 28;   // angle accumulator, units of 2^-24 rad
  localparam int SW = 57;   // square root operand width
  localparam int RW = 29;   // square root result width
  localparam int TABLE_LEN = 24;
  localparam logic signed [ZW-1:0] PI_Q24 = 28'sd52707179;
  localparam logic signed [14:0] HALF_PI_Q13 = 15'sd12868;
  localparam logic signed [AW-1:0] ONE_Q28 = 40'sd268435456;

  typedef logic signed [AW-1:0] vec_t;
  typedef logic signed [ZW-1:0] ang_t;

  typedef struct packed {
    vec_t x;
    vec_t y;
    ang_t z;
    logic zero;
  } cord_t;

  function automatic ang_t atan_entry(input int i);
    ang_t t;
    unique case (i)
      0: t = 28'sd13176795;
      1: t = 28'sd7778716;
      2: t = 28'sd4110060;
      3: t = 28'sd2086331;
      4: t = 28'sd1047214;
      5: t = 28'sd524117;
      6: t = 28'sd262123;
      7: t = 28'sd131069;
      default: t = (i < TABLE_LEN) ? ang_t'(28'sd65536 >>> (i - 8)) : '0;
    endcase
    return t;
  endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/q2e_isqrt.sv =====
// Pipelined floor square root, one result bit per stage.
// Depends on q2e_pkg.
`default_nettype none
module q2e_isqrt
  import q2e_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          en,
  input  wire logic [SW-1:0] n_in,
  output logic [RW-1:0]      root
);
  localparam int N = RW;
  logic [SW-1:0] rem_r [N+1];
  logic [RW-1:0] res_r [N+1];

  always_comb begin
    rem_r[0] = n_in;
    res_r[0] = '0;
  end

  for (genvar k = 0; k < N; k++) begin : g_st
    localparam int B = N - 1 - k;
    logic [SW-1:0] rem_q;
    logic [RW-1:0] res_q;
    logic [SW+1:0] trial;
    logic [SW-1:0] rem_nxt;
    logic [RW-1:0] res_nxt;
    always_comb begin
      trial = ({2'b0, res_r[k]} << (B + 1)) + ({{(SW+1){1'b0}}, 1'b1} << (2 * B));
      if ({2'b0, rem_r[k]} >= trial) begin
        rem_nxt = rem_r[k] - trial[SW-1:0];
        res_nxt = res_r[k] | (RW'(1) << B);
      end else begin
        rem_nxt = rem_r[k];
        res_nxt = res_r[k];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem_q <= rem_nxt;
        res_q <= res_nxt;
      end
    end
    assign rem_r[k+1] = rem_q;
    assign res_r[k+1] = res_q;
  end
  assign root = res_r[N];
endmodule
`default_nettype wire

// ===== hw/rtl/q2e_cordic.sv =====
// Pipelined vectoring CORDIC atan2, one iteration per stage, rounded to Q3.13.
// Depends on q2e_pkg.
`default_nettype none
module q2e_cordic
  import q2e_pkg::*;
#(
  parameter int STEPS = 14
) (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire vec_t        y_in,
  input  wire vec_t        x_in,
  output logic signed [15:0] angle
);
  cord_t st [STEPS+1];
  cord_t pre_r;
  cord_t pre_nxt;
  logic signed [15:0] ang_r;
  ang_t zr;

  always_comb begin
    pre_nxt.zero = (x_in == '0) && (y_in == '0);
    if (x_in < 0) begin
      pre_nxt.z = (y_in >= 0) ? PI_Q24 : -PI_Q24;
      pre_nxt.x = -x_in;
      pre_nxt.y = -y_in;
    end else begin
      pre_nxt.z = '0;
      pre_nxt.x = x_in;
      pre_nxt.y = y_in;
    end
  end
  always_ff @(posedge clk) begin
    if (en) pre_r <= pre_nxt;
  end
  assign st[0] = pre_r;

  for (genvar i = 0; i < STEPS; i++) begin : g_it
    cord_t q, nx;
    always_comb begin
      nx.zero = st[i].zero;
      if (i >= TABLE_LEN) begin
        nx = st[i];
      end else if (st[i].y >= 0) begin
        nx.x = st[i].x + (st[i].y >>> i);
        nx.y = st[i].y - (st[i].x >>> i);
        nx.z = st[i].z + atan_entry(i);
      end else begin
        nx.x = st[i].x - (st[i].y >>> i);
        nx.y = st[i].y + (st[i].x >>> i);
        nx.z = st[i].z - atan_entry(i);
      end
    end
    always_ff @(posedge clk) begin
      if (en) q <= nx;
    end
    assign st[i+1] = q;
  end

  assign zr = (st[STEPS].z + ang_t'(1024)) >>> 11;
  always_ff @(posedge clk) begin
    if (en) ang_r <= st[STEPS].zero ? 16'sd0 : zr[15:0];
  end
  assign angle = ang_r;
endmodule
`default_nettype wire

// ===== hw/rtl/quaternion_to_euler.sv =====
// Pipeline: products, sums, pitch square, square root 29 stages, then the
// CORDIC with its input register, iteration stages and output register.
// Throughput: one item per cycle; a stall freezes the whole pipeline.
// Reset: rst_n synchronous, active low, clears the valid bits only.
// Depends on q2e_pkg, q2e_isqrt, q2e_cordic and quaternion_to_euler_macros.svh.
`default_nettype none
`include "quaternion_to_euler_macros.svh"
module quaternion_to_euler
  import q2e_pkg::*;
#(
  parameter int CORDIC_STEPS = 14
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,   // quat_w, quat_x, quat_y, quat_z
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [47:0]      out_tdata,  // roll_angle, pitch_angle, yaw_angle
  output logic             out_tuser   // pitch_clamped
);
  localparam int SQ = RW;
  localparam int LAT = 3 + SQ + CORDIC_STEPS + 2;
  logic [LAT-1:0] v_r;
  logic en;
  assign en = out_tready || !out_tvalid;
  assign in_tready = en;
  assign out_tvalid = v_r[LAT-1];

  logic signed [15:0] w, x, y, z;
  assign w = in_tdata[15:0];
  assign x = in_tdata[31:16];
  assign y = in_tdata[47:32];
  assign z = in_tdata[63:48];

  // stage 1: products
  logic signed [31:0] p_wx_r, p_yz_r, p_xx_r, p_yy_r, p_wy_r, p_zx_r, p_wz_r, p_xy_r, p_zz_r;
  always_ff @(posedge clk) begin
    if (en) begin
      p_wx_r <= w * x; p_yz_r <= y * z; p_xx_r <= x * x;
      p_yy_r <= y * y; p_wy_r <= w * y; p_zx_r <= z * x;
      p_wz_r <= w * z; p_xy_r <= x * y; p_zz_r <= z * z;
    end
  end
  // stage 2: sums
  vec_t r1_r, r2_r, y1_r, z1_r, z2_r;
  always_ff @(posedge clk) begin
    if (en) begin
      r1_r <= 2 * (vec_t'(p_wx_r) + vec_t'(p_yz_r));
      r2_r <= ONE_Q28 - 2 * (vec_t'(p_xx_r) + vec_t'(p_yy_r));
      y1_r <= 2 * (vec_t'(p_wy_r) - vec_t'(p_zx_r));
      z1_r <= 2 * (vec_t'(p_wz_r) + vec_t'(p_xy_r));
      z2_r <= ONE_Q28 - 2 * (vec_t'(p_yy_r) + vec_t'(p_zz_r));
    end
  end
  // stage 3: pitch argument square; magnitude is below 2^28 unless clamped
  logic [SW-1:0] sq_arg_r;
  logic [27:0] y1_mag;
  logic [55:0] y1sq;
  assign y1_mag = y1_r[AW-1] ? 28'(-y1_r) : y1_r[27:0];
  assign y1sq = y1_mag * y1_mag;
  always_ff @(posedge clk) begin
    if (en) begin
      sq_arg_r <= (y1_r >= ONE_Q28 || y1_r <= -ONE_Q28) ? '0
                 : (SW'(1) << 56) - SW'(y1sq);
    end
  end
  // delay lines to align with square root
  vec_t r1_d [SQ+1], r2_d [SQ+1], z1_d [SQ+1], z2_d [SQ+1], y1_d [SQ+1];
  logic [1:0] cl_d [SQ+1];
  always_ff @(posedge clk) begin
    if (en) begin
      r1_d[0] <= r1_r; r2_d[0] <= r2_r; z1_d[0] <= z1_r; z2_d[0] <= z2_r;
      y1_d[0] <= y1_r; cl_d[0] <= {y1_r <= -ONE_Q28, y1_r >= ONE_Q28};
      for (int k = 1; k <= SQ; k++) begin
        r1_d[k] <= r1_d[k-1]; r2_d[k] <= r2_d[k-1]; z1_d[k] <= z1_d[k-1];
        z2_d[k] <= z2_d[k-1]; y1_d[k] <= y1_d[k-1]; cl_d[k] <= cl_d[k-1];
      end
    end
  end
  logic [RW-1:0] root;
  q2e_isqrt u_sqrt (.clk(clk), .en(en), .n_in(sq_arg_r), .root(root));

  logic signed [15:0] roll_a, pitch_a, yaw_a;
  q2e_cordic #(.STEPS(CORDIC_STEPS)) u_roll (.clk(clk), .en(en),
    .y_in(r1_d[SQ]), .x_in(r2_d[SQ]), .angle(roll_a));
  q2e_cordic #(.STEPS(CORDIC_STEPS)) u_pitch (.clk(clk), .en(en),
    .y_in(y1_d[SQ]), .x_in(vec_t'({1'b0, root})), .angle(pitch_a));
  q2e_cordic #(.STEPS(CORDIC_STEPS)) u_yaw (.clk(clk), .en(en),
    .y_in(z1_d[SQ]), .x_in(z2_d[SQ]), .angle(yaw_a));

  logic [1:0] cl_o [CORDIC_STEPS+2];
  always_ff @(posedge clk) begin
    if (en) begin
      cl_o[0] <= cl_d[SQ];
      for (int k = 1; k < CORDIC_STEPS + 2; k++) cl_o[k] <= cl_o[k-1];
    end
  end
  logic [1:0] clf;
  logic [14:0] pitch_f;
  assign clf = cl_o[CORDIC_STEPS+1];
  assign pitch_f = clf[0] ? HALF_PI_Q13 : clf[1] ? -HALF_PI_Q13 : pitch_a[14:0];
  assign out_tdata = {1'b0, yaw_a, pitch_f, roll_a};
  assign out_tuser = |clf;

  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= '0;
    else if (en) v_r <= {v_r[LAT-2:0], in_tvalid};
  end

  `Q2E_ASSERT_NXT(a_stall_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid)
  `Q2E_ASSERT_IMP(a_ready, clk, rst_n, !out_tvalid, in_tready)
  `Q2E_ASSERT_IMP(a_clamp_one, clk, rst_n, out_tvalid, !(clf[0] && clf[1]))
endmodule
`default_nettype wire
